// ===== hdl/wmcl_pkg.sv =====
// Package for the window median cost limiter.
// Field widths and default sizes; no dependencies.
package wmcl_pkg;
    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 11;
    localparam int LIMIT_W       = 31;
    localparam int DEFAULT_DEPTH = 1024;
endpackage

// ===== hdl/wmcl_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wmcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/wmcl_cost.sv =====
// Median and absolute deviation cost from half sums, compared to the limit.
// Depends on wmcl_pkg.
module wmcl_cost #(
    parameter int SUM_W = 43
) (
    input  logic signed [SUM_W-1:0]            lower_sum,
    input  logic signed [SUM_W-1:0]            upper_sum,
    input  logic signed [wmcl_pkg::VALUE_W-1:0] mid_lo,
    input  logic signed [wmcl_pkg::VALUE_W-1:0] mid_hi,
    input  logic                               odd,
    input  logic [wmcl_pkg::LIMIT_W-1:0]        limit,
    output logic                               over
);
    import wmcl_pkg::*;

    localparam int CW = SUM_W + 2;

    logic signed [VALUE_W:0]   pair_sum;
    logic signed [VALUE_W:0]   pair_adj;
    logic signed [VALUE_W:0]   mid;
    logic signed [CW-1:0]      cost;
    logic signed [CW-1:0]      lim_ext;

    always_comb
    begin
        pair_sum = (VALUE_W+1)'(mid_lo) + (VALUE_W+1)'(mid_hi);
        pair_adj = pair_sum + ((pair_sum < 0) ? (VALUE_W+1)'(1) : (VALUE_W+1)'(0));
        mid      = odd ? (VALUE_W+1)'(mid_hi) : (pair_adj >>> 1);
        cost     = CW'(upper_sum) - CW'(lower_sum) - (odd ? CW'(mid) : CW'(0));
        lim_ext  = $signed({{(CW-LIMIT_W){1'b0}}, limit});
        over     = cost > lim_ext;
    end
endmodule

// ===== hdl/window_median_cost_limiter_top.sv =====
// Top level: sequencer over the arrival ring and sorted store RAMs.
// Depends on wmcl_pkg, wmcl_ram, wmcl_cost.
//
// channel  | signals                                 | dir
// sample   | sample_valid/ready, sample_value, new_case | in
// result   | result_valid/ready, window_length, best_length, full_evicted | out
// config   | cost_limit_we, cost_limit_wdata          | in
//
// An item makes passes over the sorted store (insert, one cost scan per
// check, one shift pass per eviction), each stepping through the elements in
// turn with a RAM read state and a data state. No clearing pass after reset.
// The next item is accepted while a result waits in the output register.
module window_median_cost_limiter_top #(
    parameter int WINDOW_DEPTH = wmcl_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [wmcl_pkg::VALUE_W-1:0] sample_value,
    input  logic                                new_case,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [wmcl_pkg::LEN_W-1:0]          window_length,
    output logic [wmcl_pkg::LEN_W-1:0]          best_length,
    output logic                                full_evicted,
    input  logic                                cost_limit_we,
    input  logic [wmcl_pkg::LIMIT_W-1:0]        cost_limit_wdata
);
    import wmcl_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = VALUE_W + CW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EV_RD   = 4'd1;
    localparam logic [3:0] S_EV_DAT  = 4'd2;
    localparam logic [3:0] S_RM_RD   = 4'd3;
    localparam logic [3:0] S_RM_DAT  = 4'd4;
    localparam logic [3:0] S_PUSH    = 4'd5;
    localparam logic [3:0] S_INS_RD  = 4'd6;
    localparam logic [3:0] S_INS_DAT = 4'd7;
    localparam logic [3:0] S_INS_WR  = 4'd8;
    localparam logic [3:0] S_CHK_RD  = 4'd9;
    localparam logic [3:0] S_CHK_DAT = 4'd10;
    localparam logic [3:0] S_EVAL    = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic signed [VALUE_W-1:0] old_reg, old_next;
    logic signed [VALUE_W-1:0] a_reg, a_next;
    logic signed [VALUE_W-1:0] b_reg, b_next;
    logic signed [SW-1:0]      lo_reg, lo_next;
    logic signed [SW-1:0]      up_reg, up_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             best_reg, best_next;
    logic [CW-1:0]             j_reg, j_next;
    logic                      full_reg, full_next;
    logic                      fullph_reg, fullph_next;
    logic                      found_reg, found_next;
    logic [LIMIT_W-1:0]        limit_reg;
    logic                      ovalid_reg, ovalid_next;
    logic [LEN_W-1:0]          olen_reg, olen_next;
    logic [LEN_W-1:0]          obest_reg, obest_next;
    logic                      ofull_reg, ofull_next;

    logic                      ring_we;
    logic [AW-1:0]             ring_waddr;
    logic [VALUE_W-1:0]        ring_rdata;
    logic                      srt_we;
    logic [AW-1:0]             srt_waddr;
    logic [AW-1:0]             srt_raddr;
    logic [VALUE_W-1:0]        srt_wdata;
    logic [VALUE_W-1:0]        srt_rdata;
    logic signed [VALUE_W-1:0] d;
    logic [CW-1:0]             half;
    logic [CW-1:0]             jm1;
    logic [CW-1:0]             jp1;
    logic [CW-1:0]             cnt0;
    logic [CW:0]               slot_sum;
    logic                      over;
    logic [CW-1:0]             best_new;

    wmcl_ram #(.WIDTH(VALUE_W), .DEPTH(WINDOW_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (v_reg),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    wmcl_ram #(.WIDTH(VALUE_W), .DEPTH(WINDOW_DEPTH)) u_sorted (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    wmcl_cost #(.SUM_W(SW)) u_cost (
        .lower_sum (lo_reg),
        .upper_sum (up_reg),
        .mid_lo    (a_reg),
        .mid_hi    (b_reg),
        .odd       (count_reg[0]),
        .limit     (limit_reg),
        .over      (over)
    );

    assign sample_ready  = (state_reg == S_IDLE);
    assign result_valid  = ovalid_reg;
    assign window_length = olen_reg;
    assign best_length   = obest_reg;
    assign full_evicted  = ofull_reg;

    always_comb
    begin
        d        = $signed(srt_rdata);
        half     = count_reg >> 1;
        jm1      = j_reg - CW'(1);
        jp1      = j_reg + CW'(1);
        cnt0     = new_case ? CW'(0) : count_reg;
        slot_sum = (CW+1)'(ptr_reg) + (CW+1)'(count_reg);
        if (slot_sum >= (CW+1)'(WINDOW_DEPTH))
        begin
            slot_sum = slot_sum - (CW+1)'(WINDOW_DEPTH);
        end
        ring_waddr = slot_sum[AW-1:0];
        best_new   = (count_reg > best_reg) ? count_reg : best_reg;

        state_next  = state_reg;
        v_next      = v_reg;
        old_next    = old_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        lo_next     = lo_reg;
        up_next     = up_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        j_next      = j_reg;
        full_next   = full_reg;
        fullph_next = fullph_reg;
        found_next  = found_reg;
        ovalid_next = ovalid_reg && !result_ready;
        olen_next   = olen_reg;
        obest_next  = obest_reg;
        ofull_next  = ofull_reg;
        ring_we     = 1'b0;
        srt_we      = 1'b0;
        srt_waddr   = jm1[AW-1:0];
        srt_wdata   = d;
        srt_raddr   = j_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    v_next     = sample_value;
                    count_next = cnt0;
                    if (new_case)
                    begin
                        ptr_next  = '0;
                        best_next = '0;
                    end
                    full_next   = (cnt0 >= CW'(WINDOW_DEPTH));
                    fullph_next = (cnt0 >= CW'(WINDOW_DEPTH));
                    state_next  = (cnt0 >= CW'(WINDOW_DEPTH)) ? S_EV_RD : S_PUSH;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_DAT;
            end
            S_EV_DAT:
            begin
                old_next   = $signed(ring_rdata);
                j_next     = '0;
                found_next = 1'b0;
                state_next = S_RM_RD;
            end
            S_RM_RD:
            begin
                state_next = S_RM_DAT;
            end
            S_RM_DAT:
            begin
                if (found_reg)
                begin
                    srt_we = 1'b1;
                end
                else if (d == old_reg)
                begin
                    found_next = 1'b1;
                end
                j_next = jp1;
                if (jp1 == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    ptr_next   = (ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
                    if (fullph_reg)
                    begin
                        fullph_next = 1'b0;
                        state_next  = S_PUSH;
                    end
                    else
                    begin
                        j_next     = '0;
                        lo_next    = '0;
                        up_next    = '0;
                        state_next = S_CHK_RD;
                    end
                end
                else
                begin
                    state_next = S_RM_RD;
                end
            end
            S_PUSH:
            begin
                ring_we    = 1'b1;
                j_next     = count_reg;
                state_next = (count_reg == '0) ? S_INS_WR : S_INS_RD;
            end
            S_INS_RD:
            begin
                srt_raddr  = jm1[AW-1:0];
                state_next = S_INS_DAT;
            end
            S_INS_DAT:
            begin
                if (d > v_reg)
                begin
                    srt_we     = 1'b1;
                    srt_waddr  = j_reg[AW-1:0];
                    j_next     = jm1;
                    state_next = (jm1 == '0) ? S_INS_WR : S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                srt_we     = 1'b1;
                srt_waddr  = j_reg[AW-1:0];
                srt_wdata  = v_reg;
                count_next = count_reg + CW'(1);
                j_next     = '0;
                lo_next    = '0;
                up_next    = '0;
                state_next = S_CHK_RD;
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_DAT;
            end
            S_CHK_DAT:
            begin
                if (j_reg < half)
                begin
                    lo_next = lo_reg + SW'(d);
                end
                else
                begin
                    up_next = up_reg + SW'(d);
                end
                if (j_reg == half - CW'(1))
                begin
                    a_next = d;
                end
                if (j_reg == half)
                begin
                    b_next = d;
                end
                j_next     = jp1;
                state_next = (jp1 == count_reg) ? S_EVAL : S_CHK_RD;
            end
            S_EVAL:
            begin
                state_next = over ? S_EV_RD : S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || result_ready)
                begin
                    best_next   = best_new;
                    ovalid_next = 1'b1;
                    olen_next   = LEN_W'(count_reg);
                    obest_next  = LEN_W'(best_new);
                    ofull_next  = full_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ptr_reg    <= '0;
            count_reg  <= '0;
            best_reg   <= '0;
            j_reg      <= '0;
            full_reg   <= 1'b0;
            fullph_reg <= 1'b0;
            found_reg  <= 1'b0;
            limit_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            count_reg  <= count_next;
            best_reg   <= best_next;
            j_reg      <= j_next;
            full_reg   <= full_next;
            fullph_reg <= fullph_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
            if (cost_limit_we)
            begin
                limit_reg <= cost_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        old_reg   <= old_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        lo_reg    <= lo_next;
        up_reg    <= up_next;
        olen_reg  <= olen_next;
        obest_reg <= obest_next;
        ofull_reg <= ofull_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= AW'(WINDOW_DEPTH - 1))
        else $error("oldest pointer out of range");

    a_eval_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (count_reg != '0))
        else $error("cost check on empty window");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("accepted item did not start work");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for window_median_cost_limiter_top: random and directed samples against
// a queue-based window predictor. Depends on wmcl_pkg and the block's RTL.
module tb_top;
    import wmcl_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    typedef struct packed {
        logic [LEN_W-1:0] window_length;
        logic [LEN_W-1:0] best_length;
        logic             full_evicted;
    } window_result_t;

    class window_scoreboard;
        int                  arrivals[$];
        int                  sorted_vals[$];
        logic [LIMIT_W-1:0]  limit;
        int                  longest;
        window_result_t      expected_q[$];
        int                  errors;

        function void drop_oldest();
            int v;
            int idx;
            v = arrivals.pop_front();
            idx = 0;
            while (idx < sorted_vals.size() && sorted_vals[idx] != v)
                idx++;
            if (idx < sorted_vals.size())
                sorted_vals.delete(idx);
        endfunction

        function longint window_cost();
            int     n;
            int     half;
            longint mid;
            longint lo_sum;
            longint hi_sum;
            n = sorted_vals.size();
            half = n / 2;
            lo_sum = 0;
            hi_sum = 0;
            if (n == 0)
                return 0;
            for (int i = 0; i < n; i++)
                if (i < half)
                    lo_sum += sorted_vals[i];
                else
                    hi_sum += sorted_vals[i];
            if (n % 2 == 1)
                mid = sorted_vals[half];
            else
                mid = (longint'(sorted_vals[half-1]) + longint'(sorted_vals[half])) / 2;
            return mid * half - lo_sum + hi_sum - mid * (n - half);
        endfunction

        function void note_sample(int v, bit nc);
            int             pos;
            longint         lim;
            window_result_t e;
            lim = limit;
            e.full_evicted = 1'b0;
            if (nc)
            begin
                arrivals.delete();
                sorted_vals.delete();
                longest = 0;
            end
            if (arrivals.size() >= DEPTH)
            begin
                drop_oldest();
                e.full_evicted = 1'b1;
            end
            arrivals.insert(arrivals.size(), v);
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] <= v)
                pos++;
            sorted_vals.insert(pos, v);
            while (arrivals.size() > 0 && window_cost() > lim)
                drop_oldest();
            if (arrivals.size() > longest)
                longest = arrivals.size();
            e.window_length = LEN_W'(arrivals.size());
            e.best_length = LEN_W'(longest);
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_result(window_result_t got);
            window_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %0d %0d %0d", got.window_length,
                             got.best_length, got.full_evicted);
                return;
            end
            e = expected_q.pop_front();
            if (e !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp len %0d best %0d full %0d, got %0d %0d %0d",
                             e.window_length, e.best_length, e.full_evicted,
                             got.window_length, got.best_length, got.full_evicted);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      new_case;
    logic                      result_valid;
    logic                      result_ready;
    logic [LEN_W-1:0]          window_length;
    logic [LEN_W-1:0]          best_length;
    logic                      full_evicted;
    logic                      cost_limit_we;
    logic [LIMIT_W-1:0]        cost_limit_wdata;

    window_scoreboard sb;
    bit quiet;
    bit hold_req;

    window_median_cost_limiter_top #(.WINDOW_DEPTH(DEPTH)) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .sample_value     (sample_value),
        .new_case         (new_case),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .window_length    (window_length),
        .best_length      (best_length),
        .full_evicted     (full_evicted),
        .cost_limit_we    (cost_limit_we),
        .cost_limit_wdata (cost_limit_wdata)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random ready bursts, one long hold-off on request
    initial
    begin
        int  left;
        bit  level;
        bit  held;
        left = 0;
        level = 1'b1;
        held = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ready = 1'b0;
                repeat (3000) @(negedge clk);
                result_ready = 1'b1;
            end
            else if (quiet)
                result_ready = 1'b1;
            else
            begin
                if (left == 0)
                begin
                    level = ($urandom_range(0, 9) < 6);
                    left = level ? $urandom_range(1, 60) : $urandom_range(1, 19);
                end
                result_ready = level;
                left--;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            sb.check_result({window_length, best_length, full_evicted});

    task automatic send_sample(input logic signed [VALUE_W-1:0] v, input bit nc);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            sample_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample_value = v;
        new_case = nc;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(v, nc);
        @(negedge clk);
    endtask

    task automatic drain_and_write(input logic [LIMIT_W-1:0] lim);
        sample_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cost_limit_we = 1'b1;
        cost_limit_wdata = lim;
        sb.limit = lim;
        @(negedge clk);
        cost_limit_we = 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(int kind);
        if (kind == 0 || $urandom_range(0, 19) == 0)
            return $urandom;
        return $signed($urandom_range(0, 600)) - 300;
    endfunction

    initial
    begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int kind;
        sb = new();
        sb.limit = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_value = '0;
        new_case = 1'b0;
        cost_limit_we = 1'b0;
        cost_limit_wdata = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // limit zero: extremes, duplicates, single-sample windows
        send_sample(0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b1);

        drain_and_write(31'd10);
        send_sample(5, 1'b1);
        send_sample(5, 1'b0);
        send_sample(6, 1'b0);
        send_sample(4, 1'b0);
        send_sample(9, 1'b0);
        send_sample(100, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(2, 1'b1);
        send_sample(12, 1'b0);

        // widest limit: grow to a full store and wrap it
        drain_and_write(31'h7FFFFFFF);
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(32'sh80000000, 1'b0);
        send_sample(0, 1'b1);
        for (int i = 0; i < DEPTH + 6; i++)
            send_sample($signed($urandom_range(0, 2000)) - 1000, 1'b0);

        for (int p = 0; p < 6; p++)
        begin
            kind = p % 2;
            if (kind == 0)
                drain_and_write(LIMIT_W'($urandom));
            else
                drain_and_write(LIMIT_W'($urandom_range(0, 6000)));
            if (p == 1)
                hold_req = 1'b1;
            if (p == 5)
                quiet = 1'b1;
            for (int i = 0; i < 100; i++)
                send_sample(pick_value(kind), $urandom_range(0, 29) == 0);
        end

        sample_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
